### src/scvt_pkg.sv
// shared types and constants for the sphere cone visibility test
`timescale 1ns / 1ps
`default_nettype none

package scvt_pkg;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR_DEPTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FAR_DEPTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CONE_SINE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CONE_SEC   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ASPECT     = 3'd4;

   // register reset values
   localparam logic signed [31:0] NEAR_DEPTH_RST = 32'sd0;
   localparam logic signed [31:0] FAR_DEPTH_RST  = 32'sd65536000;
   localparam logic [16:0]        CONE_SINE_RST  = 17'd32768;
   localparam logic [22:0]        CONE_SEC_RST   = 23'd75674;
   localparam logic [18:0]        ASPECT_RST     = 19'd65536;

   // one classified item between front and back
   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [33:0] tz;
      logic [30:0]        radius;
      logic               cam;
      logic signed [17:0] ax;
      logic signed [17:0] ay;
      logic signed [17:0] az;
   } item_type;

   // widened cone sine and secant
   typedef struct packed {
      logic [31:0] sinw;
      logic [31:0] cosw;
   } cone_type;

   // configuration registers as a group
   typedef struct packed {
      logic signed [31:0] near_depth;
      logic signed [31:0] far_depth;
      logic [16:0]        sine;
      logic [22:0]        sec;
      logic [18:0]        aspect;
   } csr_type;

endpackage

`default_nettype wire

### src/scvt_queue.sv
// small register queue, depth a power of two
`timescale 1ns / 1ps
`default_nettype none

module scvt_queue #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  full,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rptr_ff];

   // pointer and fill count
   always_comb begin
      wptr_in = do_wr ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_rd ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

### src/scvt_front.sv
// front end: takes input beats, forms eye offsets and the clip-mode z shift
`timescale 1ns / 1ps
`default_nettype none

module scvt_front
   import scvt_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic signed [31:0] req_obj_x,
   input  wire logic signed [31:0] req_obj_y,
   input  wire logic signed [31:0] req_obj_z,
   input  wire logic [30:0]        req_obj_radius,
   input  wire logic               req_camera_clip,
   input  wire logic signed [31:0] req_eye_x,
   input  wire logic signed [31:0] req_eye_y,
   input  wire logic signed [31:0] req_eye_z,
   input  wire logic signed [17:0] req_axis_x,
   input  wire logic signed [17:0] req_axis_y,
   input  wire logic signed [17:0] req_axis_z,
   input  wire logic               busy,
   input  wire logic               q_full,
   output logic                    q_push,
   output item_type                q_item
);

   localparam logic [30:0] R_TWO = 31'(2) << FRAC_BITS;
   localparam logic [30:0] R_TEN = 31'(10) << FRAC_BITS;

   logic               hold_v_ff, hold_v_in;
   item_type           hold_ff, hold_in;
   logic               take;
   logic               clip_band;
   logic signed [32:0] dz_c;

   assign full   = busy || (hold_v_ff && q_full);
   assign take   = push && !full;
   assign q_push = hold_v_ff && !q_full;
   assign q_item = hold_ff;

   // offsets from the eye; clip-mode spheres with 2 < radius < 10 move along z by their radius
   always_comb begin
      dz_c      = $signed({req_obj_z[31], req_obj_z}) - $signed({req_eye_z[31], req_eye_z});
      clip_band = req_camera_clip && (req_obj_radius > R_TWO) && (req_obj_radius < R_TEN);
      hold_in.dx = $signed({req_obj_x[31], req_obj_x}) - $signed({req_eye_x[31], req_eye_x});
      hold_in.dy = $signed({req_obj_y[31], req_obj_y}) - $signed({req_eye_y[31], req_eye_y});
      hold_in.tz = clip_band ? $signed({dz_c[32], dz_c}) + $signed({3'b000, req_obj_radius})
                             : $signed({dz_c[32], dz_c});
      hold_in.radius = req_obj_radius;
      hold_in.cam    = req_camera_clip;
      hold_in.ax     = req_axis_x;
      hold_in.ay     = req_axis_y;
      hold_in.az     = req_axis_z;
   end

   // holding stage valid
   always_comb begin
      hold_v_in = hold_v_ff;
      if (take) begin
         hold_v_in = 1'b1;
      end else if (q_push) begin
         hold_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_ff <= hold_in;
      end
   end

endmodule

`default_nettype wire

### src/scvt_cone.sv
// cone derivation: widened tangent, secant by square root, sine by division
`timescale 1ns / 1ps
`default_nettype none

module scvt_cone
   import scvt_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        restart,
   input  wire logic [16:0] sine,
   input  wire logic [22:0] sec,
   input  wire logic [18:0] aspect,
   output cone_type         cone,
   output logic             busy
);

   localparam int unsigned F     = FRAC_BITS;
   localparam int unsigned T_W   = 41;
   localparam int unsigned NUM_W = 31 + F;
   localparam int unsigned CNT_W = $clog2(NUM_W);
   localparam logic [63:0] K_WIDE = ((64'd173205948 << F) + 64'd50000000) / 64'd100000000;
   localparam logic [63:0] ONE_SQ = 64'd1 << (2 * F);
   localparam logic [63:0] TAN_CAP = 64'd2147483647;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_T0   = 3'd1;
   localparam logic [2:0] S_T1   = 3'd2;
   localparam logic [2:0] S_T2   = 3'd3;
   localparam logic [2:0] S_SQ   = 3'd4;
   localparam logic [2:0] S_SQRT = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [T_W-1:0]   t_ff, t_in;
   logic [30:0]      tc_ff, tc_in;
   logic [63:0]      v_ff, v_in;
   logic [63:0]      res_ff, res_in;
   logic [63:0]      bit_ff, bit_in;
   logic [31:0]      cosw_ff, cosw_in;
   logic [32:0]      rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [63:0] prod;
   logic [63:0] shifted;
   logic [63:0] trial;
   logic [32:0] rem_sh;

   assign busy      = (state_ff != S_IDLE);
   assign cone.cosw = cosw_ff;
   assign cone.sinw = q_ff[31:0];

   // sequencer: one multiply, one root step or one quotient bit per cycle
   always_comb begin
      state_in = state_ff;
      t_in     = t_ff;
      tc_in    = tc_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      cosw_in  = cosw_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      prod     = '0;
      shifted  = '0;
      trial    = res_ff + bit_ff;
      rem_sh   = {rem_ff[31:0], num_ff[NUM_W-1]};
      unique case (state_ff)
         S_IDLE: begin
         end
         S_T0: begin
            prod     = 64'(sine) * 64'(sec);
            t_in     = T_W'(prod >> F);
            state_in = S_T1;
         end
         S_T1: begin
            prod     = 64'(t_ff) * K_WIDE;
            t_in     = T_W'(prod >> F);
            state_in = S_T2;
         end
         S_T2: begin
            prod     = 64'(t_ff) * 64'(aspect);
            shifted  = prod >> F;
            tc_in    = (shifted > TAN_CAP) ? TAN_CAP[30:0] : shifted[30:0];
            state_in = S_SQ;
         end
         S_SQ: begin
            v_in     = ONE_SQ + 64'(tc_ff) * 64'(tc_ff);
            res_in   = '0;
            bit_in   = 64'd1 << 62;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               cosw_in  = res_in[31:0];
               rem_in   = '0;
               num_in   = NUM_W'(tc_ff) << F;
               q_in     = '0;
               cnt_in   = CNT_W'(NUM_W - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_sh >= {1'b0, cosw_ff}) begin
               rem_in = rem_sh - {1'b0, cosw_ff};
               q_in   = {q_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               q_in   = {q_ff[NUM_W-2:0], 1'b0};
            end
            num_in = num_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (restart) begin
         state_in = S_T0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_T0;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      tc_ff   <= tc_in;
      v_ff    <= v_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      cosw_ff <= cosw_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
   end

endmodule

`default_nettype wire

### src/scvt_back.sv
// back end: nine-stage pipeline from offsets to the visible decision
`timescale 1ns / 1ps
`default_nettype none

module scvt_back
   import scvt_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  item_type                in_item,
   output logic                    take,
   input  wire logic signed [31:0] near_depth,
   input  wire logic signed [31:0] far_depth,
   input  cone_type                cone,
   input  wire logic               out_full,
   output logic                    out_push,
   output logic                    out_visible
);

   localparam int unsigned F    = FRAC_BITS;
   localparam int unsigned DW   = 55 - F;
   localparam int unsigned AW   = ((DW > 32) ? DW : 32) + 1;
   localparam int unsigned CW   = ((DW > 33) ? DW : 33) + 1;
   localparam int unsigned CR_W = AW + 33;
   localparam int unsigned DLO  = DW / 2;
   localparam int unsigned DHI  = DW - DLO;
   localparam int unsigned RW   = ((2 * DW > 69) ? 2 * DW : 69) + 1;
   localparam logic [30:0] R_TEN  = 31'(10) << F;
   localparam logic [31:0] R_FIVE = 32'(5) << F;
   localparam logic [40:0] CONE_CAP = 41'd1 << 40;

   typedef struct packed {
      logic [68:0] dist2;
      logic [63:0] rsq;
      logic [68:0] radial;
      logic        zero;
      logic        fail;
      logic        cam;
      logic        big;
   } side_type;

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;

   assign adv         = !v9_ff || !out_full;
   assign take        = adv && in_valid;
   assign out_push    = v9_ff && !out_full;

   // valid bits move together
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
         v7_ff <= 1'b0; v8_ff <= 1'b0; v9_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff; v7_ff <= v6_ff;
         v8_ff <= v7_ff; v9_ff <= v8_ff;
      end
   end

   // stage 1: squares, dot terms, sphere radius squared
   logic [65:0]        dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [67:0]        tz2_ff, tz2_in;
   logic signed [51:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [30:0]        r1_ff;
   side_type           s1_ff, s1_in;
   logic [31:0]        rr_c;

   always_comb begin
      dx2_in = in_item.dx * in_item.dx;
      dy2_in = in_item.dy * in_item.dy;
      tz2_in = in_item.tz * in_item.tz;
      px_in  = in_item.dx * in_item.ax;
      py_in  = in_item.dy * in_item.ay;
      pz_in  = in_item.tz * in_item.az;
      s1_in  = '0;
      s1_in.cam = in_item.cam;
      s1_in.big = (in_item.radius >= R_TEN);
      rr_c      = s1_in.big ? 32'(in_item.radius) + R_FIVE : 32'(in_item.radius);
      s1_in.rsq = 64'(rr_c) * 64'(rr_c);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx2_ff <= dx2_in; dy2_ff <= dy2_in; tz2_ff <= tz2_in;
         px_ff  <= px_in;  py_ff  <= py_in;  pz_ff  <= pz_in;
         r1_ff  <= in_item.radius;
         s1_ff  <= s1_in;
      end
   end

   // stage 2: squared distance and depth along the axis
   logic signed [53:0]   dot_c;
   logic signed [54:0]   ndot_c;
   logic signed [DW-1:0] depth2_ff, depth2_in;
   logic [30:0]          r2_ff;
   side_type             s2_ff, s2_in;

   always_comb begin
      dot_c     = 54'(px_ff) + 54'(py_ff) + 54'(pz_ff);
      ndot_c    = 55'sd0 - $signed({dot_c[53], dot_c});
      depth2_in = ndot_c[54:F];
      s2_in       = s1_ff;
      s2_in.dist2 = 69'(dx2_ff) + 69'(dy2_ff) + 69'(tz2_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         depth2_ff <= depth2_in;
         r2_ff     <= r1_ff;
         s2_ff     <= s2_in;
      end
   end

   // stage 3: depth window, depth times sine, partial squares of depth
   logic signed [32:0]      low_c, high_c;
   logic signed [CW-1:0]    dep_x, low_x, high_x;
   logic signed [DW+F+1:0]  ds3_ff, ds3_in;
   logic [DW-1:0]           dmag_c;
   logic [2*DHI-1:0]        dhh_ff, dhh_in;
   logic [DHI+DLO-1:0]      dhl_ff, dhl_in;
   logic [2*DLO-1:0]        dll_ff, dll_in;
   logic [30:0]             r3_ff;
   side_type                s3_ff, s3_in;

   always_comb begin
      low_c  = $signed({near_depth[31], near_depth}) - $signed({2'b00, r2_ff});
      high_c = $signed({far_depth[31], far_depth}) + $signed({2'b00, r2_ff});
      dep_x  = CW'(depth2_ff);
      low_x  = CW'(low_c);
      high_x = CW'(high_c);
      s3_in      = s2_ff;
      s3_in.zero = (s2_ff.dist2 == '0);
      s3_in.fail = (dep_x < low_x) || (dep_x > high_x);
      ds3_in = depth2_ff * $signed({1'b0, cone.sinw[F:0]});
      dmag_c = depth2_ff[DW-1] ? DW'(-depth2_ff) : DW'(depth2_ff);
      dhh_in = dmag_c[DW-1:DLO] * dmag_c[DW-1:DLO];
      dhl_in = dmag_c[DW-1:DLO] * dmag_c[DLO-1:0];
      dll_in = dmag_c[DLO-1:0] * dmag_c[DLO-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ds3_ff <= ds3_in;
         dhh_ff <= dhh_in; dhl_ff <= dhl_in; dll_ff <= dll_in;
         r3_ff  <= r2_ff;
         s3_ff  <= s3_in;
      end
   end

   // stage 4: axial offset of the cone edge, depth squared
   logic signed [DW-1:0] dfl_c;
   logic signed [AW-1:0] a4_ff, a4_in;
   logic [2*DW-1:0]      dsq4_ff, dsq4_in;
   side_type             s4_ff;

   always_comb begin
      dfl_c   = ds3_ff[F+DW-1:F];
      a4_in   = AW'(dfl_c) + $signed(AW'(r3_ff));
      dsq4_in = ((2*DW)'(dhh_ff) << (2 * DLO)) + ((2*DW)'(dhl_ff) << (DLO + 1))
              + (2*DW)'(dll_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a4_ff   <= a4_in;
         dsq4_ff <= dsq4_in;
         s4_ff   <= s3_ff;
      end
   end

   // stage 5: radial distance squared, cone radius before scaling
   logic signed [RW-1:0]   rad_c;
   logic signed [CR_W-1:0] cr5_ff, cr5_in;
   side_type               s5_ff, s5_in;

   always_comb begin
      rad_c  = $signed(RW'(s4_ff.dist2)) - $signed(RW'(dsq4_ff));
      s5_in  = s4_ff;
      s5_in.radial = rad_c[RW-1] ? '0 : rad_c[68:0];
      cr5_in = a4_ff * $signed({1'b0, cone.cosw});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cr5_ff <= cr5_in;
         s5_ff  <= s5_in;
      end
   end

   // stage 6: magnitude, scale down, saturate
   logic [CR_W-1:0] crabs_c, crs_c;
   logic [40:0]     m6_ff, m6_in;
   side_type        s6_ff;

   always_comb begin
      crabs_c = cr5_ff[CR_W-1] ? CR_W'(-cr5_ff) : CR_W'(cr5_ff);
      crs_c   = crabs_c >> F;
      m6_in   = (crs_c > CR_W'(CONE_CAP)) ? CONE_CAP : crs_c[40:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m6_ff <= m6_in;
         s6_ff <= s5_ff;
      end
   end

   // stage 7: partial products of the cone radius squared
   logic [41:0] mhh_ff;
   logic [40:0] mhl_ff;
   logic [39:0] mll_ff;
   side_type    s7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mhh_ff <= m6_ff[40:20] * m6_ff[40:20];
         mhl_ff <= m6_ff[40:20] * m6_ff[19:0];
         mll_ff <= m6_ff[19:0] * m6_ff[19:0];
         s7_ff  <= s6_ff;
      end
   end

   // stage 8: cone radius squared
   logic [81:0] cr2_ff, cr2_in;
   side_type    s8_ff;

   assign cr2_in = (82'(mhh_ff) << 40) + (82'(mhl_ff) << 21) + 82'(mll_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         cr2_ff <= cr2_in;
         s8_ff  <= s7_ff;
      end
   end

   // stage 9: decision
   logic        vis9_ff, vis9_in;
   logic [81:0] quad_c, radial_x, dist_x, rsq_x;

   always_comb begin
      radial_x = 82'(s8_ff.radial);
      quad_c   = 82'({s8_ff.radial, 2'b00});
      dist_x   = 82'(s8_ff.dist2);
      rsq_x    = 82'(s8_ff.rsq);
      if (s8_ff.zero) begin
         vis9_in = 1'b1;
      end else if (s8_ff.fail) begin
         vis9_in = 1'b0;
      end else if (!(radial_x < cr2_ff)) begin
         vis9_in = 1'b0;
      end else if (!s8_ff.cam) begin
         vis9_in = 1'b1;
      end else if (!s8_ff.big && (quad_c < cr2_ff)) begin
         vis9_in = 1'b1;
      end else begin
         vis9_in = !(dist_x < rsq_x);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vis9_ff <= vis9_in;
      end
   end

   assign out_visible = vis9_ff;

endmodule

`default_nettype wire

### src/sphere_cone_visibility_test.sv
// top level of the sphere against view cone visibility test
//
// Input channel: present a sphere, eye and axis on the req_ ports and raise
// push; the beat is taken at a clock edge where push is high and full low.
// Result channel: while empty is low, rsp_visible holds the oldest result;
// raising pop takes it. One result is produced for every input beat, in order.
// Configuration: csr_index/csr_data with valid/ready, ready always high.
// Any write restarts the cone derivation unit, which computes the widened
// sine and secant (Q16.16 when FRAC_BITS is 16) from the cone and aspect
// registers; full stays high meanwhile. The same pass runs after reset, so
// the first beat is taken only after it completes. Throughput is one beat
// per cycle, set by the nine-stage back pipeline, while no cone derivation
// runs and pop keeps the result side drained. From accept to empty falling
// the beat passes the front holding stage, the mid queue, the nine pipeline
// stages and the output queue write.
// When pop stays low the back pipeline holds, then the four-entry queue
// between front and back fills, and full rises.
`timescale 1ns / 1ps
`default_nettype none

module sphere_cone_visibility_test
   import scvt_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic signed [31:0]   req_obj_x,
   input  wire logic signed [31:0]   req_obj_y,
   input  wire logic signed [31:0]   req_obj_z,
   input  wire logic [30:0]          req_obj_radius,
   input  wire logic                 req_camera_clip,
   input  wire logic signed [31:0]   req_eye_x,
   input  wire logic signed [31:0]   req_eye_y,
   input  wire logic signed [31:0]   req_eye_z,
   input  wire logic signed [17:0]   req_axis_x,
   input  wire logic signed [17:0]   req_axis_y,
   input  wire logic signed [17:0]   req_axis_z,
   output logic                      empty,
   input  wire logic                 pop,
   output logic                      rsp_visible,
   input  wire logic                 valid,
   output logic                      ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data
);

   csr_type  csr_ff, csr_in;
   cone_type cone;
   item_type q_wr_item, q_rd_item;
   logic     csr_wr;
   logic     busy;
   logic     q_push, q_full, q_empty, q_take;
   logic     o_push, o_full, o_vis;

   assign ready  = 1'b1;
   assign csr_wr = valid && ready;

   // configuration register file
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr) begin
         unique case (csr_index)
            REG_NEAR_DEPTH: csr_in.near_depth = csr_data;
            REG_FAR_DEPTH:  csr_in.far_depth  = csr_data;
            REG_CONE_SINE:  csr_in.sine       = csr_data[16:0];
            REG_CONE_SEC:   csr_in.sec        = csr_data[22:0];
            REG_ASPECT:     csr_in.aspect     = csr_data[18:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.near_depth <= NEAR_DEPTH_RST;
         csr_ff.far_depth  <= FAR_DEPTH_RST;
         csr_ff.sine       <= CONE_SINE_RST;
         csr_ff.sec        <= CONE_SEC_RST;
         csr_ff.aspect     <= ASPECT_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // cone derivation
   scvt_cone #(.FRAC_BITS(FRAC_BITS)) u_cone (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_wr),
      .sine    (csr_ff.sine),
      .sec     (csr_ff.sec),
      .aspect  (csr_ff.aspect),
      .cone    (cone),
      .busy    (busy)
   );

   // front end
   scvt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_obj_x       (req_obj_x),
      .req_obj_y       (req_obj_y),
      .req_obj_z       (req_obj_z),
      .req_obj_radius  (req_obj_radius),
      .req_camera_clip (req_camera_clip),
      .req_eye_x       (req_eye_x),
      .req_eye_y       (req_eye_y),
      .req_eye_z       (req_eye_z),
      .req_axis_x      (req_axis_x),
      .req_axis_y      (req_axis_y),
      .req_axis_z      (req_axis_z),
      .busy            (busy),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_wr_item)
   );

   // decoupling queue between front and back
   scvt_queue #(.WIDTH($bits(item_type)), .DEPTH(4)) u_mid_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_item),
      .rd_en   (q_take),
      .rd_data (q_rd_item),
      .full    (q_full),
      .empty   (q_empty)
   );

   // back pipeline
   scvt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (!q_empty),
      .in_item     (q_rd_item),
      .take        (q_take),
      .near_depth  (csr_ff.near_depth),
      .far_depth   (csr_ff.far_depth),
      .cone        (cone),
      .out_full    (o_full),
      .out_push    (o_push),
      .out_visible (o_vis)
   );

   // result queue
   scvt_queue #(.WIDTH(1), .DEPTH(2)) u_out_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (o_push),
      .wr_data (o_vis),
      .rd_en   (pop),
      .rd_data (rsp_visible),
      .full    (o_full),
      .empty   (empty)
   );

   // no beat is taken while the cone values are being derived
   assert property (@(posedge clock) disable iff (reset) busy |-> full)
      else $error("input taken during cone derivation");

   // a configuration write closes the input side on the next cycle
   assert property (@(posedge clock) disable iff (reset) (valid && ready) |=> full)
      else $error("input open right after configuration write");

   // reset leaves no stale result
   assert property (@(posedge clock) reset |=> empty)
      else $error("result present after reset");

endmodule

`default_nettype wire
